### rtl/rrts_pkg.sv
// shared constants, codes and control structs of the round-robin thread scheduler
`default_nettype none

package rrts_pkg;

  // table sizes
  localparam int NUM_THREADS = 8;
  localparam int NUM_MUTEXES = 8;

  localparam int SLOT_W  = $clog2(NUM_THREADS);
  localparam int MUTEX_W = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam int CNT_W   = $clog2(NUM_THREADS + 1);

  // command codes
  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_CREATE = 3'd1,
    CMD_TICK   = 3'd2,
    CMD_EXIT   = 3'd3,
    CMD_MENTER = 3'd4,
    CMD_MEXIT  = 3'd5
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    RS_OK       = 3'd0,
    RS_UNINIT   = 3'd1,
    RS_NOSLOT   = 3'd2,
    RS_NOTOWNER = 3'd3,
    RS_IDLE     = 3'd4
  } status_t;

  // thread slot states
  typedef enum logic [2:0] {
    SL_DONE    = 3'd0,
    SL_NEW     = 3'd1,
    SL_READY   = 3'd2,
    SL_RUNNING = 3'd3,
    SL_WAITING = 3'd4
  } slot_state_t;

  // what the token looks for while it walks the cells
  typedef enum logic {
    MODE_RR   = 1'b0,
    MODE_FREE = 1'b1
  } scan_mode_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SCAN = 2'd2,
    S_FIN  = 2'd3
  } fsm_t;

  // broadcast control into the row of slot cells
  typedef struct packed {
    logic                 init_all;
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_idx;
    slot_state_t          wr_state;
    logic                 wr_wait_en;
    logic [MUTEX_W-1:0]   wr_wait;
    logic                 inject;
    logic [SLOT_W-1:0]    start_idx;
    logic                 scan;
    scan_mode_t           mode;
  } cell_ctl_t;

  // status seen from one slot cell
  typedef struct packed {
    slot_state_t          state;
    logic [MUTEX_W-1:0]   wait_m;
    logic                 win;
  } cell_stat_t;

  // mutex table update
  typedef struct packed {
    logic                 acq;
    logic                 rel;
    logic [MUTEX_W-1:0]   idx;
    logic [SLOT_W-1:0]    owner;
  } mtx_ctl_t;

endpackage

`default_nettype wire

### rtl/rrts_slot_cell.sv
// one thread slot: state, wait mutex and the scan token handed to the next slot
`default_nettype none

module rrts_slot_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [rrts_pkg::SLOT_W-1:0]      my_idx,
  input  wire rrts_pkg::cell_ctl_t              ctl,
  input  wire logic [rrts_pkg::NUM_MUTEXES-1:0] held_vec,
  input  wire logic                             tok_in,
  output logic                                  tok_out,
  output rrts_pkg::cell_stat_t                  stat
);

  rrts_pkg::slot_state_t              state_r, state_nxt;
  logic [rrts_pkg::MUTEX_W-1:0]       wait_r, wait_nxt;
  logic                               tok_r, tok_nxt;
  logic                               match;
  logic                               win;

  // does this slot satisfy the walking token
  always_comb begin
    if (ctl.mode == rrts_pkg::MODE_FREE) begin
      match = (state_r == rrts_pkg::SL_DONE);
    end else begin
      match = (state_r == rrts_pkg::SL_NEW) || (state_r == rrts_pkg::SL_READY) ||
              ((state_r == rrts_pkg::SL_WAITING) && !held_vec[wait_r]);
    end
  end

  assign win     = tok_r && match;
  assign tok_out = tok_r && !match;

  // token moves one slot per cycle while the scan runs
  assign tok_nxt = (ctl.inject && (ctl.start_idx == my_idx)) || (ctl.scan && tok_in);

  // slot state update
  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    priority if (ctl.init_all) begin
      state_nxt = (my_idx == '0) ? rrts_pkg::SL_RUNNING : rrts_pkg::SL_DONE;
      wait_nxt  = '0;
    end else if (win) begin
      if (ctl.mode == rrts_pkg::MODE_FREE) begin
        state_nxt = rrts_pkg::SL_NEW;
      end else begin
        state_nxt = rrts_pkg::SL_RUNNING;
        if (state_r == rrts_pkg::SL_WAITING) begin
          wait_nxt = '0;
        end
      end
    end else if (ctl.wr_en && (ctl.wr_idx == my_idx)) begin
      state_nxt = ctl.wr_state;
      if (ctl.wr_wait_en) begin
        wait_nxt = ctl.wr_wait;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrts_pkg::SL_DONE;
      wait_r  <= '0;
      tok_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign stat.state  = state_r;
  assign stat.wait_m = wait_r;
  assign stat.win    = win;

endmodule

`default_nettype wire

### rtl/rrts_mutex_table.sv
// mutex held flags and owner slots
`default_nettype none

module rrts_mutex_table (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire rrts_pkg::mtx_ctl_t               ctl,
  input  wire logic [rrts_pkg::MUTEX_W-1:0]     rd_idx,
  output logic [rrts_pkg::NUM_MUTEXES-1:0]      held_vec,
  output logic [rrts_pkg::SLOT_W-1:0]           rd_owner
);

  logic [rrts_pkg::NUM_MUTEXES-1:0] held_r, held_nxt;
  logic [rrts_pkg::SLOT_W-1:0]      owner_r   [rrts_pkg::NUM_MUTEXES];
  logic [rrts_pkg::SLOT_W-1:0]      owner_nxt [rrts_pkg::NUM_MUTEXES];

  // acquire or release one entry
  always_comb begin
    held_nxt  = held_r;
    owner_nxt = owner_r;
    if (ctl.acq) begin
      held_nxt[ctl.idx]  = 1'b1;
      owner_nxt[ctl.idx] = ctl.owner;
    end else if (ctl.rel) begin
      held_nxt[ctl.idx]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  // owner is only meaningful while held
  always_ff @(posedge clk) begin
    owner_r <= owner_nxt;
  end

  assign held_vec = held_r;
  assign rd_owner = owner_r[rd_idx];

endmodule

`default_nettype wire

### rtl/round_robin_thread_scheduler.sv
// top level: command sequencer, row of slot cells and mutex table
//
// Usage: one command beat (in_cmd, in_mutex_id) enters on the in_ channel
// and produces exactly one result beat on the out_ channel, both with
// valid/ready handshakes. Commands are handled one at a time.
// Commands that do not scan (init, mutex exit, a granted or rejected mutex
// enter, errors) pass from the execute state straight to the finish state.
// Create, tick, exit and a blocking mutex enter first run a scan, in which a
// token walks along the slot cells: it moves one slot per cycle until a slot
// takes it or it has visited all NUM_THREADS slots. A new command can be
// taken in the cycle after the result is loaded.
// The result sits in an output register; the next command is accepted
// while it waits. If out_ready stays low the sequencer holds the next
// result and no further command is taken until the register drains.
// Reset (rst_n low, synchronous) marks all slots done, frees all mutexes
// and leaves the scheduler uninitialized; no clearing pass is needed.
`default_nettype none

module round_robin_thread_scheduler (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_cmd,
  input  wire logic [2:0] in_mutex_id,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_status,
  output logic [2:0]      out_running_thread,
  output logic [2:0]      out_new_slot,
  output logic            out_lock_granted,
  output logic [3:0]      out_live_threads
);

  localparam int N  = rrts_pkg::NUM_THREADS;
  localparam int SW = rrts_pkg::SLOT_W;
  localparam int MW = rrts_pkg::MUTEX_W;
  localparam int CW = rrts_pkg::CNT_W;

  rrts_pkg::fsm_t         state_r, state_nxt;
  logic [2:0]             cmd_r;
  logic [2:0]             mid_r;
  logic [SW-1:0]          cur_r, cur_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [SW-1:0]          step_r, step_nxt;
  rrts_pkg::scan_mode_t   mode_r, mode_nxt;
  rrts_pkg::status_t      status_r, status_nxt;
  logic [SW-1:0]          new_slot_r, new_slot_nxt;
  logic                   granted_r, granted_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             out_status_r;
  logic [2:0]             out_running_r;
  logic [2:0]             out_new_slot_r;
  logic                   out_granted_r;
  logic [3:0]             out_live_r;

  rrts_pkg::cell_ctl_t    cell_ctl;
  rrts_pkg::cell_stat_t   cell_stat [N];
  logic [N-1:0]           tok_vec;
  logic [N-1:0]           win_vec;
  rrts_pkg::mtx_ctl_t     mtx_ctl;
  logic [rrts_pkg::NUM_MUTEXES-1:0] held_vec;
  logic [SW-1:0]          mid_owner;

  logic                   in_fire;
  logic                   out_load;
  logic                   uninit;
  logic                   cur_running;
  logic                   mid_ok;
  logic [MW-1:0]          mid_idx;
  logic                   mid_held;
  logic                   exec_scan;
  logic [SW-1:0]          cur_inc;
  logic                   last_step;
  logic                   win_any;
  logic [SW-1:0]          win_idx;
  logic                   win_waiting;
  logic [MW-1:0]          win_wait;

  // row of slot cells, token ring closes from the last slot back to slot 0
  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int PREV = (i == 0) ? N - 1 : i - 1;
    rrts_slot_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .my_idx   (SW'(i)),
      .ctl      (cell_ctl),
      .held_vec (held_vec),
      .tok_in   (tok_vec[PREV]),
      .tok_out  (tok_vec[i]),
      .stat     (cell_stat[i])
    );
    assign win_vec[i] = cell_stat[i].win;
  end

  rrts_mutex_table u_mtx (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mtx_ctl),
    .rd_idx   (mid_idx),
    .held_vec (held_vec),
    .rd_owner (mid_owner)
  );

  // handshake
  assign in_ready = (state_r == rrts_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == rrts_pkg::S_FIN) && (!out_valid_r || out_ready);

  // command decode helpers
  assign uninit      = (cnt_r == '0);
  assign cur_running = (cell_stat[cur_r].state == rrts_pkg::SL_RUNNING);
  assign mid_ok      = ({29'd0, mid_r} < 32'(rrts_pkg::NUM_MUTEXES));
  assign mid_idx     = MW'(mid_r);
  assign mid_held    = held_vec[mid_idx];
  assign cur_inc     = (cur_r == SW'(N - 1)) ? '0 : cur_r + 1'b1;
  assign last_step   = (step_r == SW'(N - 1));

  assign exec_scan = !uninit &&
                     ((cmd_r == rrts_pkg::CMD_CREATE) || (cmd_r == rrts_pkg::CMD_TICK) ||
                      (cmd_r == rrts_pkg::CMD_EXIT) ||
                      ((cmd_r == rrts_pkg::CMD_MENTER) && cur_running && mid_ok && mid_held));

  // winner encode, at most one cell holds the token
  always_comb begin
    win_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (win_vec[i]) begin
        win_idx = win_idx | SW'(i);
      end
    end
  end

  assign win_any     = |win_vec;
  assign win_waiting = (cell_stat[win_idx].state == rrts_pkg::SL_WAITING);
  assign win_wait    = cell_stat[win_idx].wait_m;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrts_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = rrts_pkg::S_EXEC;
        end
      end
      rrts_pkg::S_EXEC: begin
        state_nxt = exec_scan ? rrts_pkg::S_SCAN : rrts_pkg::S_FIN;
      end
      rrts_pkg::S_SCAN: begin
        if (win_any || last_step) begin
          state_nxt = rrts_pkg::S_FIN;
        end
      end
      rrts_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = rrts_pkg::S_IDLE;
        end
      end
      default: state_nxt = rrts_pkg::S_IDLE;
    endcase
  end

  // datapath control and register updates
  always_comb begin
    cell_ctl      = '0;
    cell_ctl.mode = mode_r;
    mtx_ctl       = '0;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    mode_nxt      = mode_r;
    status_nxt    = status_r;
    new_slot_nxt  = new_slot_r;
    granted_nxt   = granted_r;
    unique case (state_r)
      rrts_pkg::S_IDLE: begin
        if (in_fire) begin
          status_nxt   = rrts_pkg::RS_OK;
          new_slot_nxt = '0;
          granted_nxt  = 1'b0;
        end
      end
      rrts_pkg::S_EXEC: begin
        step_nxt = '0;
        if ((cmd_r == rrts_pkg::CMD_INIT) && uninit) begin
          // start with slot 0 running
          cell_ctl.init_all = 1'b1;
          cnt_nxt           = CW'(1);
          cur_nxt           = '0;
        end else if ((cmd_r != rrts_pkg::CMD_INIT) && (cmd_r <= rrts_pkg::CMD_MEXIT) &&
                     uninit) begin
          status_nxt = rrts_pkg::RS_UNINIT;
        end else if (cmd_r == rrts_pkg::CMD_CREATE) begin
          // search for the first done slot from slot 0
          cell_ctl.inject    = 1'b1;
          cell_ctl.start_idx = '0;
          mode_nxt           = rrts_pkg::MODE_FREE;
        end else if ((cmd_r == rrts_pkg::CMD_TICK) || (cmd_r == rrts_pkg::CMD_EXIT)) begin
          cell_ctl.wr_en    = cur_running;
          cell_ctl.wr_idx   = cur_r;
          if (cmd_r == rrts_pkg::CMD_TICK) begin
            cell_ctl.wr_state = rrts_pkg::SL_READY;
          end else begin
            cell_ctl.wr_state = rrts_pkg::SL_DONE;
            if (cur_running) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          cell_ctl.inject    = 1'b1;
          cell_ctl.start_idx = cur_inc;
          mode_nxt           = rrts_pkg::MODE_RR;
        end else if (((cmd_r == rrts_pkg::CMD_MENTER) || (cmd_r == rrts_pkg::CMD_MEXIT)) &&
                     !cur_running) begin
          status_nxt = rrts_pkg::RS_IDLE;
        end else if (cmd_r == rrts_pkg::CMD_MENTER) begin
          if (mid_ok && !mid_held) begin
            mtx_ctl.acq   = 1'b1;
            mtx_ctl.idx   = mid_idx;
            mtx_ctl.owner = cur_r;
            granted_nxt   = 1'b1;
          end else if (mid_ok) begin
            // block on the mutex and pick another thread
            cell_ctl.wr_en      = 1'b1;
            cell_ctl.wr_idx     = cur_r;
            cell_ctl.wr_state   = rrts_pkg::SL_WAITING;
            cell_ctl.wr_wait_en = 1'b1;
            cell_ctl.wr_wait    = mid_idx;
            cell_ctl.inject     = 1'b1;
            cell_ctl.start_idx  = cur_inc;
            mode_nxt            = rrts_pkg::MODE_RR;
          end
        end else if (cmd_r == rrts_pkg::CMD_MEXIT) begin
          if (mid_ok && mid_held && (mid_owner == cur_r)) begin
            mtx_ctl.rel = 1'b1;
            mtx_ctl.idx = mid_idx;
          end else begin
            status_nxt = rrts_pkg::RS_NOTOWNER;
          end
        end
      end
      rrts_pkg::S_SCAN: begin
        if (win_any) begin
          if (mode_r == rrts_pkg::MODE_FREE) begin
            new_slot_nxt = win_idx;
            cnt_nxt      = cnt_r + 1'b1;
          end else begin
            cur_nxt = win_idx;
            if (win_waiting) begin
              mtx_ctl.acq   = 1'b1;
              mtx_ctl.idx   = win_wait;
              mtx_ctl.owner = win_idx;
            end
          end
        end else if (last_step) begin
          status_nxt = (mode_r == rrts_pkg::MODE_FREE) ? rrts_pkg::RS_NOSLOT
                                                       : rrts_pkg::RS_IDLE;
        end else begin
          cell_ctl.scan = 1'b1;
          step_nxt      = step_r + 1'b1;
        end
      end
      rrts_pkg::S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrts_pkg::S_IDLE;
      cur_r       <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      mode_r      <= rrts_pkg::MODE_RR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_cmd;
      mid_r <= in_mutex_id;
    end
    status_r   <= status_nxt;
    new_slot_r <= new_slot_nxt;
    granted_r  <= granted_nxt;
    if (out_load) begin
      out_status_r   <= status_r;
      out_running_r  <= 3'(cur_r);
      out_new_slot_r <= 3'(new_slot_r);
      out_granted_r  <= granted_r;
      out_live_r     <= 4'(cnt_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_running_thread = out_running_r;
  assign out_new_slot       = out_new_slot_r;
  assign out_lock_granted   = out_granted_r;
  assign out_live_threads   = out_live_r;

  // only one slot may take the token
  a_single_winner: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(win_vec))
    else $error("more than one slot won the scan");

  // a round-robin winner is the running slot afterwards
  a_winner_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrts_pkg::S_SCAN && win_any && mode_r == rrts_pkg::MODE_RR) |=>
      (cell_stat[cur_r].state == rrts_pkg::SL_RUNNING))
    else $error("scan winner is not running");

  // live thread count never exceeds the slot count
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(N))
    else $error("live thread count out of range");

  // a result only appears from the finish state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rrts_pkg::S_FIN))
    else $error("result loaded outside finish state");

  // tokens only walk while scanning
  a_token_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrts_pkg::S_IDLE) |-> (win_vec == '0 && tok_vec == '0))
    else $error("scan token alive while idle");

endmodule

`default_nettype wire
